FILE: rtl/bcr_pkg.sv
// Shared types and constants for the bracket command recognizer.
package bcr_pkg;

  localparam int unsigned NUM_CMDS      = 7;
  localparam int unsigned TEXT_MAX      = 12;
  localparam int unsigned ROOM_TEXT_LEN = 8;

  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;

  localparam logic [3:0] ROOM_MAX = 4'd8;
  localparam logic [3:0] ROOM_SAT = 4'd9;

  typedef enum logic [2:0] {
    CMD_UNKNOWN = 3'd0,
    CMD_ROOM    = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_RESET   = 3'd4,
    CMD_STATUS  = 3'd5,
    CMD_LOAD    = 3'd6,
    CMD_UNLOAD  = 3'd7
  } cmd_e;

  // Command texts, left-justified, first character in the top byte.
  // Entry 0 is the lowest slice, so the list runs from last command to first.
  localparam logic [NUM_CMDS-1:0][TEXT_MAX*8-1:0] CMD_TEXT = {
    "[f,unload,1]",
    {"[f,load,1]", 16'h0000},
    {"[f,status]", 16'h0000},
    {"[f,reset]", 24'h000000},
    {"[f,stop]", 32'h00000000},
    {"[f,start]", 24'h000000},
    {"[f,room,", 32'h00000000}
  };

  localparam logic [NUM_CMDS-1:0][3:0] CMD_LEN = {
    4'd12, 4'd10, 4'd10, 4'd9, 4'd8, 4'd9, 4'd8
  };

  typedef struct packed {
    cmd_e       command;
    logic [3:0] room;
    logic       room_ok;
  } result_t;

endpackage

FILE: rtl/bcr_in_stage.sv
// Input register: holds one received byte until the parser takes it.
module bcr_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o,
  input  logic       pop_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

FILE: rtl/bcr_parser.sv
// Frame tracker: prefix matching, room digit accumulation and command decode.
module bcr_parser #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_valid_i,
  input  logic [7:0]      byte_i,
  input  logic            out_free_i,
  output logic            pop_o,
  output logic            emit_o,
  output bcr_pkg::result_t result_o
);

  localparam int unsigned PW = $clog2(FRAME_BYTES);

  logic                          frame_q, frame_d;
  logic [PW-1:0]                 pos_q, pos_d;
  logic [bcr_pkg::NUM_CMDS-1:0]  alive_q, alive_d;
  logic [3:0]                    accum_q, accum_d;
  logic                          digits_q, digits_d;

  logic       is_close;
  logic [3:0] cmp_sel;
  logic [6:0] accum_next;
  logic       is_digit;

  // A closing byte needs a free result slot; everything else moves on.
  assign is_close = frame_q && (byte_i == bcr_pkg::CHAR_RBRACKET);
  assign pop_o    = byte_valid_i && (!is_close || out_free_i);

  assign cmp_sel    = 4'(bcr_pkg::TEXT_MAX - 1) - pos_q[3:0];
  assign is_digit   = (byte_i >= bcr_pkg::CHAR_ZERO) && (byte_i <= bcr_pkg::CHAR_NINE);
  assign accum_next = {accum_q, 3'b000} + {2'b00, accum_q, 1'b0} + {3'b000, byte_i[3:0]};

  always_comb begin
    frame_d  = frame_q;
    pos_d    = pos_q;
    alive_d  = alive_q;
    accum_d  = accum_q;
    digits_d = digits_q;
    emit_o   = 1'b0;
    result_o = '{command: bcr_pkg::CMD_UNKNOWN, room: 4'd0, room_ok: 1'b0};

    if (pop_o) begin
      if (byte_i == bcr_pkg::CHAR_LBRACKET) begin
        frame_d  = 1'b1;
        pos_d    = PW'(1);
        alive_d  = '1;
        accum_d  = 4'd0;
        digits_d = 1'b0;
      end else if (frame_q) begin
        if (pos_q < PW'(FRAME_BYTES - 1)) begin
          if (digits_q) begin
            if (is_digit) begin
              accum_d = (accum_q > bcr_pkg::ROOM_MAX || accum_next > 7'(bcr_pkg::ROOM_MAX))
                        ? bcr_pkg::ROOM_SAT : accum_next[3:0];
            end else begin
              digits_d = 1'b0;
            end
          end
          for (int k = 0; k < bcr_pkg::NUM_CMDS; k++) begin
            if (pos_q < PW'(bcr_pkg::CMD_LEN[k]) &&
                byte_i != bcr_pkg::CMD_TEXT[k][{cmp_sel, 3'b000} +: 8]) begin
              alive_d[k] = 1'b0;
            end
          end
          if (pos_q == PW'(bcr_pkg::ROOM_TEXT_LEN - 1) && alive_d[0]) begin
            digits_d = 1'b1;
          end
          pos_d = pos_q + PW'(1);
        end

        if (is_close) begin
          emit_o = 1'b1;
          // Scan downward so the first matching text wins.
          for (int k = bcr_pkg::NUM_CMDS - 1; k >= 0; k--) begin
            if (alive_d[k] && pos_d >= PW'(bcr_pkg::CMD_LEN[k])) begin
              result_o.command = bcr_pkg::cmd_e'(3'(k + 1));
            end
          end
          if (result_o.command == bcr_pkg::CMD_ROOM && accum_d >= 4'd1 &&
              accum_d <= bcr_pkg::ROOM_MAX) begin
            result_o.room    = accum_d;
            result_o.room_ok = 1'b1;
          end
          frame_d  = 1'b0;
          pos_d    = '0;
          alive_d  = '0;
          accum_d  = 4'd0;
          digits_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= 1'b0;
      pos_q    <= '0;
      alive_q  <= '0;
      accum_q  <= 4'd0;
      digits_q <= 1'b0;
    end else begin
      frame_q  <= frame_d;
      pos_q    <= pos_d;
      alive_q  <= alive_d;
      accum_q  <= accum_d;
      digits_q <= digits_d;
    end
  end

endmodule

FILE: rtl/bcr_out_stage.sv
// Result register: holds one decoded command until the consumer takes it.
module bcr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bcr_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       command_o,
  output logic [3:0]       room_o,
  output logic             room_ok_o
);

  logic             valid_q, valid_d;
  bcr_pkg::result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign command_o   = res_q.command;
  assign room_o      = res_q.room;
  assign room_ok_o   = res_q.room_ok;

endmodule

FILE: rtl/bracket_command_recognizer_top.sv
// Flow: a byte is registered on acceptance and decoded the next cycle; a closing
// ']' then loads its result into the result register once that register is free.
// Throughput: one byte per cycle; a closing byte waits in the input register only
// while the result register holds an untaken transaction.
// Reset: rst_ni asynchronously clears the frame state and both valid flags; the
// block leaves reset outside any frame.
module bracket_command_recognizer_top #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] command_o,
  output logic [3:0] room_o,
  output logic       room_ok_o
);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             pop;
  logic             emit;
  logic             out_free;
  bcr_pkg::result_t result;

  bcr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_q),
    .pop_i        (pop)
  );

  bcr_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_q),
    .out_free_i   (out_free),
    .pop_o        (pop),
    .emit_o       (emit),
    .result_o     (result)
  );

  bcr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .command_o   (command_o),
    .room_o      (room_o),
    .room_ok_o   (room_ok_o)
  );

endmodule

FILE: rtl/bcr_checker.sv
// Port-level checks for the bracket command recognizer, bound to the top level.
module bcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] command_o,
  input logic [3:0] room_o,
  input logic       room_ok_o
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o) &&
    $stable(room_o) && $stable(room_ok_o))
    else $error("result changed while stalled");

  // A draining consumer never blocks the input.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while the consumer is ready");

  a_ok_is_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && room_ok_o |-> command_o == bcr_pkg::CMD_ROOM)
    else $error("room_ok set on a non-room command");

  a_room_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && room_ok_o |-> room_o >= 4'd1 && room_o <= bcr_pkg::ROOM_MAX)
    else $error("room out of range with room_ok set");

  a_room_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !room_ok_o |-> room_o == 4'd0)
    else $error("room nonzero without room_ok");

endmodule

bind bracket_command_recognizer_top bcr_checker u_bcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .command_o   (command_o),
  .room_o      (room_o),
  .room_ok_o   (room_ok_o)
);
